// ----- rtl/hrac_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package hrac_pkg;

    // field widths
    localparam int TIME_W  = 32;
    localparam int LEVEL_W = 18;
    localparam int AGE_W   = 7;
    localparam int BPM_W   = 8;
    localparam int CLASS_W = 2;
    localparam int CFG_W   = 18;

    // shared divider operand widths
    localparam int DIVIDEND_W = 16;
    localparam int DIVISOR_W  = 12;

    localparam int RING_DEPTH_DEFAULT = 5;

    localparam logic [LEVEL_W-1:0]    PRESENCE_RESET = 18'd50000;
    localparam logic [AGE_W-1:0]      AGE_RESET      = 7'd25;
    localparam logic [TIME_W-1:0]     MIN_INTERVAL   = 32'd236;
    localparam logic [TIME_W-1:0]     MAX_INTERVAL   = 32'd2999;
    localparam logic [DIVIDEND_W-1:0] MS_PER_MINUTE  = 16'd60000;

    // age bands and their normal limits
    localparam logic [AGE_W-1:0] AGE_CHILD_MAX = 7'd17;
    localparam logic [AGE_W-1:0] AGE_ADULT_MAX = 7'd40;
    localparam logic [AGE_W-1:0] AGE_MID_MAX   = 7'd60;
    localparam logic [BPM_W-1:0] LO_CHILD  = 8'd70;
    localparam logic [BPM_W-1:0] HI_CHILD  = 8'd100;
    localparam logic [BPM_W-1:0] LO_ADULT  = 8'd60;
    localparam logic [BPM_W-1:0] HI_ADULT  = 8'd100;
    localparam logic [BPM_W-1:0] LO_MID    = 8'd60;
    localparam logic [BPM_W-1:0] HI_MID    = 8'd95;
    localparam logic [BPM_W-1:0] LO_SENIOR = 8'd50;
    localparam logic [BPM_W-1:0] HI_SENIOR = 8'd90;

    // rhythm class codes
    localparam logic [CLASS_W-1:0] CLASS_NONE   = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_LOW    = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_NORMAL = 2'd2;
    localparam logic [CLASS_W-1:0] CLASS_HIGH   = 2'd3;

    // register indexes
    localparam logic CFG_PRESENCE = 1'b0;
    localparam logic CFG_AGE      = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RATE_GO,
        ST_RATE_WAIT,
        ST_SUM,
        ST_AVG_GO,
        ST_AVG_WAIT,
        ST_DONE
    } hrac_state_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/hrac_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module hrac_div
    import hrac_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;

    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W+1:0]  diff;

    assign shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W);
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            // trial subtract; keep the difference when it does not go negative
            if (!diff[DIVISOR_W+1])
            begin
                rem_next = diff[DIVISOR_W-1:0];
            end
            else
            begin
                rem_next = shifted[DIVISOR_W-1:0];
            end
            quo_next = {quo_reg[DIVIDEND_W-2:0], ~diff[DIVISOR_W+1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg) && !busy_reg)
        else $error("divider done without a running division");

    a_zero_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> req.divisor != '0)
        else $error("divider started with zero divisor");
`endif

endmodule

`default_nettype wire

// ----- rtl/hrac_class.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Rhythm class of an average against the age band limits.
module hrac_class
    import hrac_pkg::*;
(
    input  wire logic [BPM_W-1:0]   average,
    input  wire logic [AGE_W-1:0]   age,
    output logic      [CLASS_W-1:0] rhythm
);

    logic [BPM_W-1:0] lo_lim;
    logic [BPM_W-1:0] hi_lim;

    always_comb
    begin
        if (age <= AGE_CHILD_MAX)
        begin
            lo_lim = LO_CHILD;
            hi_lim = HI_CHILD;
        end
        else if (age <= AGE_ADULT_MAX)
        begin
            lo_lim = LO_ADULT;
            hi_lim = HI_ADULT;
        end
        else if (age <= AGE_MID_MAX)
        begin
            lo_lim = LO_MID;
            hi_lim = HI_MID;
        end
        else
        begin
            lo_lim = LO_SENIOR;
            hi_lim = HI_SENIOR;
        end

        if (average == '0)
        begin
            rhythm = CLASS_NONE;
        end
        else if (average < lo_lim)
        begin
            rhythm = CLASS_LOW;
        end
        else if (average > hi_lim)
        begin
            rhythm = CLASS_HIGH;
        end
        else
        begin
            rhythm = CLASS_NORMAL;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/heart_rate_average_classifier_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Pulse rate moving average and rhythm classifier. Each sample transfer on the
// s_ side carries a timestamp, an IR level and a beat flag; each produces
// exactly one result transfer on the m_ side. A beat seen with the finger
// present measures the interval since the previous beat (modulo 2^32); an
// interval of 236..2999 ms gives 60000/interval bpm, which enters a ring of
// RING_DEPTH rates, and the average is the floor of the ring sum over
// RING_DEPTH. One restoring divider (one quotient bit per cycle, 16 bits) is
// shared by the rate and the average divisions. A sample that stores no rate
// goes from idle straight to the result stage; one that stores a rate passes
// through the rate division, the ring summing loop and the average division
// first. s_tready is high only while the sequencer is idle. The result sits
// in an output register, so the next sample is taken while the previous
// result still waits. Configuration writes land at once and are meant for
// when the block is idle.
module heart_rate_average_classifier_top
    import hrac_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEFAULT
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,

    // sample stream
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [55:0]       s_tdata,   // time_ms[31:0], ir_level[49:32],
                                              // beat_seen[50], zero fill

    // result stream
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic      [15:0]       m_tdata,   // average_bpm[7:0],
                                              // rhythm_class[9:8],
                                              // finger_present[10],
                                              // rate_accepted[11], zero fill

    // configuration writes
    input  wire logic              cfg_we,
    input  wire logic              cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_wdata
);

    localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int SUM_W = $clog2(RING_DEPTH * 255 + 1);

    // sample fields
    logic [TIME_W-1:0]  in_time;
    logic [LEVEL_W-1:0] in_level;
    logic               in_beat;

    assign in_time  = s_tdata[31:0];
    assign in_level = s_tdata[49:32];
    assign in_beat  = s_tdata[50];

    // configuration
    logic [LEVEL_W-1:0] presence_threshold_reg;
    logic [AGE_W-1:0]   user_age_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            presence_threshold_reg <= PRESENCE_RESET;
            user_age_reg           <= AGE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PRESENCE: presence_threshold_reg <= cfg_wdata[LEVEL_W-1:0];
                CFG_AGE:      user_age_reg           <= cfg_wdata[AGE_W-1:0];
                default:      ;
            endcase
        end
    end

    // sequencer and datapath state
    hrac_state_t          state_reg, state_next;
    logic [TIME_W-1:0]    last_beat_reg;
    logic [DIVISOR_W-1:0] interval_reg;
    logic [BPM_W-1:0]     ring_reg [RING_DEPTH];
    logic [IDX_W-1:0]     ring_pos_reg;
    logic [IDX_W-1:0]     sum_idx_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [BPM_W-1:0]     average_reg;
    logic                 present_reg;
    logic                 accepted_reg;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [15:0]          m_tdata_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic               in_accept;
    logic               present;
    logic [TIME_W-1:0]  interval;
    logic               in_range;
    logic               sum_last;
    logic               out_load;
    logic [CLASS_W-1:0] rhythm;

    assign in_accept = s_tvalid && s_tready;
    assign present   = (in_level >= presence_threshold_reg);
    assign interval  = in_time - last_beat_reg;
    assign in_range  = (interval >= MIN_INTERVAL) && (interval <= MAX_INTERVAL);
    assign sum_last  = (sum_idx_reg == IDX_W'(RING_DEPTH - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (present && in_beat && in_range)
                    begin
                        state_next = ST_RATE_GO;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_RATE_GO:   state_next = ST_RATE_WAIT;
            ST_RATE_WAIT: if (div_rsp.done) state_next = ST_SUM;
            ST_SUM:       if (sum_last) state_next = ST_AVG_GO;
            ST_AVG_GO:    state_next = ST_AVG_WAIT;
            ST_AVG_WAIT:  if (div_rsp.done) state_next = ST_DONE;
            ST_DONE:      if (out_load) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_tready         = 1'b0;
        out_load         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = MS_PER_MINUTE;
        div_req.divisor  = interval_reg;
        unique case (state_reg)
            ST_IDLE:    s_tready = 1'b1;
            ST_RATE_GO: div_req.start = 1'b1;
            ST_AVG_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DIVIDEND_W'(sum_reg);
                div_req.divisor  = DIVISOR_W'(RING_DEPTH);
            end
            ST_DONE:    out_load = !m_tvalid_reg || m_tready;
            default:    ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            last_beat_reg <= '0;
            ring_pos_reg  <= '0;
            sum_idx_reg   <= '0;
            average_reg   <= '0;
            present_reg   <= 1'b0;
            accepted_reg  <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            for (int i = 0; i < RING_DEPTH; i++)
            begin
                ring_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (in_accept)
            begin
                present_reg  <= present;
                accepted_reg <= 1'b0;
                // last beat time moves on every beat with the finger present, in range or not
                if (present && in_beat)
                begin
                    last_beat_reg <= in_time;
                end
            end
            if (state_reg == ST_RATE_WAIT && div_rsp.done)
            begin
                ring_reg[ring_pos_reg] <= div_rsp.quotient[BPM_W-1:0];
                ring_pos_reg <= (ring_pos_reg == IDX_W'(RING_DEPTH - 1)) ?
                                '0 : ring_pos_reg + 1'b1;
                sum_idx_reg  <= '0;
            end
            if (state_reg == ST_SUM)
            begin
                sum_idx_reg <= sum_idx_reg + 1'b1;
            end
            if (state_reg == ST_AVG_WAIT && div_rsp.done)
            begin
                average_reg  <= div_rsp.quotient[BPM_W-1:0];
                accepted_reg <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            interval_reg <= interval[DIVISOR_W-1:0];
        end
        if (state_reg == ST_RATE_WAIT)
        begin
            sum_reg <= '0;
        end
        else if (state_reg == ST_SUM)
        begin
            sum_reg <= sum_reg + SUM_W'(ring_reg[sum_idx_reg]);
        end
        if (out_load)
        begin
            m_tdata_reg <= {4'b0000, accepted_reg, present_reg, rhythm, average_reg};
        end
    end

    assign m_tvalid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
    assign m_tvalid      = m_tvalid_reg;
    assign m_tdata       = m_tdata_reg;

    hrac_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    hrac_class u_class (
        .average (average_reg),
        .age     (user_age_reg),
        .rhythm  (rhythm)
    );

`ifndef SYNTHESIS
    a_ring_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        ring_pos_reg <= IDX_W'(RING_DEPTH - 1))
        else $error("ring position out of range");

    a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg == ST_RATE_GO || state_reg == ST_DONE)
        else $error("accepted sample did not start processing");

    a_accepted_needs_finger: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && m_tdata_reg[11] |-> m_tdata_reg[10])
        else $error("rate accepted without finger present");

    a_load_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> m_tvalid_reg && state_reg == ST_IDLE)
        else $error("result load did not reach output");
`endif

endmodule

`default_nettype wire

// ----- bench/tb_heart_rate_average_classifier_top.sv -----
`timescale 1ns / 1ps

// Bench for the pulse rate averager. Sample transfers are queued by the
// stimulus block and sent by a clocked driver. A clocked monitor predicts
// one reading per accepted sample and compares every result transfer.
module tb_heart_rate_average_classifier_top;
    import hrac_pkg::*;

    localparam int RATE_SLOTS = RING_DEPTH_DEFAULT;
    localparam int LONG_HOLD  = 400;    // cycles the result side holds off
    localparam int MAX_REPORT = 10;

    typedef struct {
        logic [TIME_W-1:0]  time_ms;
        logic [LEVEL_W-1:0] ir_level;
        logic               beat_seen;
    } sample_t;

    typedef struct {
        logic [BPM_W-1:0]   avg_bpm;
        logic [CLASS_W-1:0] rhythm;
        logic               finger;
        logic               stored;
    } reading_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [55:0]       s_tdata = '0;    // time_ms[31:0], ir_level[49:32],
                                        // beat_seen[50], zero fill
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [15:0]       m_tdata;         // average_bpm[7:0], rhythm_class[9:8],
                                        // finger_present[10], rate_accepted[11]
    logic              cfg_we = 1'b0;
    logic              cfg_index = CFG_PRESENCE;
    logic [CFG_W-1:0]  cfg_wdata = '0;

    heart_rate_average_classifier_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // samples waiting to be sent, readings waiting to come back
    sample_t  pending_samples[$];
    reading_t due_readings[$];

    // predictor copy of the block's registers and state
    logic [LEVEL_W-1:0] cur_thr = PRESENCE_RESET;
    logic [AGE_W-1:0]   cur_age = AGE_RESET;
    logic [TIME_W-1:0]  beat_stamp = '0;
    logic [BPM_W-1:0]   rate_hist[RATE_SLOTS];
    int unsigned        hist_slot = 0;
    logic [BPM_W-1:0]   held_avg = '0;

    // stimulus-side tracking so beat intervals can be aimed
    logic [TIME_W-1:0]  gen_last_beat = '0;
    logic [TIME_W-1:0]  gen_clock = '0;

    // knobs shared by the stimulus block and the two clocked processes
    logic               idle_on = 1'b1;
    int unsigned        hold_asks = 0;
    int unsigned        hold_seen = 0;
    int unsigned        hold_left = 0;
    int unsigned        tx_gap = 0;
    int unsigned        rx_gap = 0;
    sample_t            tx_item;

    // bookkeeping
    int unsigned        mismatches = 0;
    int unsigned        samples_sent = 0;
    int unsigned        readings_seen = 0;
    int unsigned        rates_taken = 0;
    int unsigned        reg_writes = 0;
    int unsigned        class_hits[4] = '{0, 0, 0, 0};

    initial
    begin
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [CLASS_W-1:0] rhythm_of(input logic [BPM_W-1:0] bpm,
                                                     input logic [AGE_W-1:0] age);
        logic [BPM_W-1:0] lo;
        logic [BPM_W-1:0] hi;
        // age zero falls into the youngest band
        if (age <= AGE_CHILD_MAX)
        begin
            lo = LO_CHILD;
            hi = HI_CHILD;
        end
        else if (age <= AGE_ADULT_MAX)
        begin
            lo = LO_ADULT;
            hi = HI_ADULT;
        end
        else if (age <= AGE_MID_MAX)
        begin
            lo = LO_MID;
            hi = HI_MID;
        end
        else
        begin
            lo = LO_SENIOR;
            hi = HI_SENIOR;
        end
        if (bpm == 0)
            return CLASS_NONE;
        if (bpm < lo)
            return CLASS_LOW;
        if (bpm > hi)
            return CLASS_HIGH;
        return CLASS_NORMAL;
    endfunction

    // Advances the predicted state by one sample and returns its reading.
    function automatic reading_t track_sample(input sample_t s);
        reading_t          r;
        logic [TIME_W-1:0] gap;
        int unsigned       total;
        r.finger = (s.ir_level >= cur_thr);
        r.stored = 1'b0;
        // no finger: the beat flag is dropped and nothing moves
        if (r.finger && s.beat_seen)
        begin
            gap = s.time_ms - beat_stamp;     // wraps mod 2^32
            beat_stamp = s.time_ms;           // updated even when out of range
            if (gap >= MIN_INTERVAL && gap <= MAX_INTERVAL)
            begin
                rate_hist[hist_slot] = BPM_W'(32'(MS_PER_MINUTE) / gap);
                hist_slot = (hist_slot == RATE_SLOTS - 1) ? 0 : hist_slot + 1;
                total = 0;
                for (int i = 0; i < RATE_SLOTS; i++)
                    total += rate_hist[i];
                held_avg = BPM_W'(total / RATE_SLOTS);
                r.stored = 1'b1;
                rates_taken++;
            end
        end
        r.avg_bpm = held_avg;
        r.rhythm  = rhythm_of(held_avg, cur_age);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: sends queued samples, with random gaps while idle_on is set
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            tx_gap   <= 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            // the slot is free: previous transfer done or nothing offered
            if (tx_gap != 0)
            begin
                tx_gap   <= tx_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (idle_on && pending_samples.size() != 0 && $urandom_range(0, 7) == 0)
            begin
                tx_gap   <= $urandom_range(0, 9);
                s_tvalid <= 1'b0;
            end
            else if (pending_samples.size() != 0)
            begin
                tx_item = pending_samples.pop_front();
                s_tdata  <= {5'b0, tx_item.beat_seen, tx_item.ir_level, tx_item.time_ms};
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result side ready: long hold-off on request, else random bursts
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_gap   <= 0;
        end
        else if (hold_seen != hold_asks)
        begin
            hold_seen <= hold_asks;
            hold_left <= LONG_HOLD;
            m_tready  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (rx_gap != 0)
        begin
            rx_gap   <= rx_gap - 1;
            m_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            rx_gap   <= $urandom_range(0, 9);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Monitor: predict on each sample transfer, check each result transfer
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        sample_t  seen;
        reading_t got;
        reading_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                seen.time_ms   = s_tdata[31:0];
                seen.ir_level  = s_tdata[49:32];
                seen.beat_seen = s_tdata[50];
                due_readings.push_back(track_sample(seen));
                samples_sent++;
            end
            if (m_tvalid && m_tready)
            begin
                got.avg_bpm = m_tdata[7:0];
                got.rhythm  = m_tdata[9:8];
                got.finger  = m_tdata[10];
                got.stored  = m_tdata[11];
                readings_seen++;
                class_hits[got.rhythm]++;
                if (due_readings.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORT)
                        $display("%0t: unexpected result transfer, data %h", $realtime, m_tdata);
                end
                else
                begin
                    want = due_readings.pop_front();
                    if (got.avg_bpm !== want.avg_bpm || got.rhythm !== want.rhythm ||
                        got.finger !== want.finger || got.stored !== want.stored)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORT)
                            $display({"%0t: reading %0d: exp avg %0d class %0d finger %0d ",
                                      "stored %0d, got avg %0d class %0d finger %0d ",
                                      "stored %0d"},
                                     $realtime, readings_seen,
                                     want.avg_bpm, want.rhythm, want.finger, want.stored,
                                     got.avg_bpm, got.rhythm, got.finger, got.stored);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_sample(input logic [TIME_W-1:0] t, input logic [LEVEL_W-1:0] ir,
                               input logic beat);
        sample_t s;
        s.time_ms   = t;
        s.ir_level  = ir;
        s.beat_seen = beat;
        if (beat && ir >= cur_thr)
            gen_last_beat = t;
        pending_samples.push_back(s);
    endtask

    // interval to the next beat: mostly plausible pulse, plus range edges
    // and intervals that must be rejected
    function automatic logic [TIME_W-1:0] beat_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return $urandom_range(500, 1300);
        if (r < 83)
            return $urandom_range(236, 2999);
        if (r < 86)
            return MIN_INTERVAL;
        if (r < 89)
            return MAX_INTERVAL;
        if (r < 93)
            return $urandom_range(0, 235);
        if (r < 97)
            return $urandom_range(3000, 100000);
        return $urandom();
    endfunction

    // Mostly a finger resting on the sensor with beats at aimed intervals
    // and quiet samples between them; the rest is noise on every field.
    task automatic add_samples(input int count);
        int unsigned pick;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
                push_sample($urandom(), LEVEL_W'($urandom_range(0, 2**LEVEL_W - 1)),
                            1'($urandom_range(0, 1)));
            else if (pick < 45)
            begin
                gen_clock = gen_last_beat + beat_gap();
                push_sample(gen_clock, LEVEL_W'($urandom_range(cur_thr, 2**LEVEL_W - 1)), 1'b1);
            end
            else
            begin
                gen_clock += $urandom_range(1, 40);
                push_sample(gen_clock, LEVEL_W'($urandom_range(cur_thr, 2**LEVEL_W - 1)), 1'b0);
            end
        end
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_PRESENCE)
            cur_thr = val;
        else
            cur_age = val[AGE_W-1:0];
        reg_writes++;
        @(negedge clk);
    endtask

    // wait until every queued sample went out and every reading came back
    task automatic drain();
        do
            @(negedge clk);
        while (pending_samples.size() != 0 || s_tvalid || due_readings.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] age,
                             input int count);
        write_reg(CFG_PRESENCE, thr);
        write_reg(CFG_AGE, age);
        add_samples(count);
        drain();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        for (int i = 0; i < RATE_SLOTS; i++)
            rate_hist[i] = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at reset settings (threshold 50000, age 25).
        push_sample(32'd1000, 18'd0, 1'b1);             // no finger, beat ignored
        push_sample(32'd1000, 18'd49999, 1'b1);         // one below threshold
        push_sample(32'd500, 18'd50000, 1'b0);          // finger on, no beat
        push_sample(32'd0, 18'd50000, 1'b1);            // zero interval
        push_sample(32'd235, 18'h3FFFF, 1'b1);          // one below range
        push_sample(32'd471, 18'd50000, 1'b1);          // shortest accepted: 254 bpm
        push_sample(32'd3470, 18'd50000, 1'b1);         // longest accepted: 20 bpm
        push_sample(32'd6470, 18'd50000, 1'b1);         // one above range
        push_sample(32'd7470, 18'd50000, 1'b1);
        push_sample(32'd8470, 18'd50000, 1'b1);
        push_sample(32'd9470, 18'd50000, 1'b1);         // ring now full
        push_sample(32'd10470, 18'd50000, 1'b1);        // oldest rate overwritten
        push_sample(32'hFFFF_FF00, 18'd50000, 1'b1);    // huge gap
        push_sample(32'h0000_0200, 18'd50000, 1'b1);    // across the wrap: 768 ms
        push_sample(32'hFFFF_FFFF, 18'h3FFFF, 1'b0);    // all-ones time and level, no beat
        push_sample(32'h0000_0390, 18'h3FFFF, 1'b1);    // 400 ms gaps push the
        push_sample(32'h0000_0520, 18'h3FFFF, 1'b1);    // average into the high
        push_sample(32'h0000_06B0, 18'h3FFFF, 1'b1);    // class
        push_sample(32'h0000_0840, 18'h3FFFF, 1'b1);
        push_sample(32'd0, 18'h3FFFF, 1'b1);            // backwards in time
        push_sample(32'd0, 18'd0, 1'b0);                // all-zero fields
        drain();
        gen_clock = gen_last_beat;

        // Random phases over thresholds and every age band edge.
        run_phase(18'd50000, 18'd25, 100);
        run_phase(18'd0, 18'd1, 90);                    // every sample present
        run_phase(18'h3FFFF, 18'd127, 60);              // only full level present

        // Age field with junk above its 7 bits: the register keeps age zero.
        // The sender pauses half way until every reading is back.
        write_reg(CFG_PRESENCE, 18'd40000);
        write_reg(CFG_AGE, 18'h3FF80);
        add_samples(45);
        drain();
        add_samples(45);
        drain();

        run_phase(18'd20000, 18'd17, 90);

        // Result side stalls for a long stretch while samples keep coming,
        // so the block backs up and drops s_tready.
        write_reg(CFG_PRESENCE, 18'd20000);
        write_reg(CFG_AGE, 18'd18);
        add_samples(90);
        hold_asks <= hold_asks + 1;
        drain();

        run_phase(18'd75000, 18'd40, 90);
        run_phase(18'd75000, 18'd41, 90);
        run_phase(18'd100000, 18'd60, 90);

        // last stretch runs at full rate on both sides
        idle_on <= 1'b0;
        run_phase(18'd100000, 18'd61, 90);

        repeat (60) @(negedge clk);
        mismatches += due_readings.size();

        $display("Sent %0d samples, checked %0d readings, %0d rates stored, %0d register writes.",
                 samples_sent, readings_seen, rates_taken, reg_writes);
        $display("Classes seen: none %0d, low %0d, normal %0d, high %0d; mismatches %0d.",
                 class_hits[CLASS_NONE], class_hits[CLASS_LOW], class_hits[CLASS_NORMAL],
                 class_hits[CLASS_HIGH], mismatches);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // hang guard, several times the slowest legal run
    initial
    begin
        #(5_000_000);
        $display("Timeout: %0d readings still due, %0d samples unsent",
                 due_readings.size(), pending_samples.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
